### rtl/core/kpt_pkg.sv
// Shared types and constants for the key pair table.
// Depends on nothing; every other file in rtl/core imports it.
package kpt_pkg;

  localparam int KEY_W       = 16;
  localparam int COUNT_OUT_W = 5;

  // Request type codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // Write port source select
  typedef enum logic [2:0] {
    W_NONE,
    W_APPEND,
    W_MOVE,
    W_SHIFT,
    W_LAST
  } wsel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;        // capture the request word, clear per-request state
    logic  clr_walk;    // rewind the slot walker
    logic  walk;        // advance the slot walker by one read
    logic  full_bound;  // walk up to the table depth instead of the count
    logic  rd_last;     // read the last valid slot and drop the count
    wsel_t wsel;        // what the write port stores this cycle
    logic  cnt_inc;     // bump the count after an append
    logic  mark_evict;  // flag the result as an eviction
    logic  emit;        // load the result register
  } kpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rd_hit;    // slot just read matches the request key
    logic walk_end;  // walker has covered every slot up to its bound
    logic take;      // current request is a take
    logic full;      // every slot holds a key
    logic out_free;  // result register can take a new word
  } kpt_sts_t;

endpackage

### rtl/core/kpt_if.sv
// Request and response channel interfaces for the key pair table.
// Depends on kpt_pkg for the key width.
interface kpt_req_if import kpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, req_type, key_code, input ready);
  modport sink   (input valid, req_type, key_code, output ready);
endinterface

interface kpt_rsp_if import kpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic                   evicted;
  logic [KEY_W-1:0]       evicted_key;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, hit, evicted, evicted_key, entry_count, input ready);
  modport sink   (input valid, hit, evicted, evicted_key, entry_count, output ready);
endinterface

### rtl/core/kpt_datapath.sv
// Datapath of the key pair table: slot memory, slot walker, count and result register.
// Depends on kpt_pkg and kpt_if; driven by commands from kpt_ctrl.
module kpt_datapath import kpt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  kpt_cmd_t         cmd,
  output kpt_sts_t         sts,
  input  logic             req_type,
  input  logic [KEY_W-1:0] key_code,
  kpt_rsp_if.source        rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

  logic [KEY_W-1:0] key_slots [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata;
  logic [KEY_W-1:0] key;
  logic             take;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic             pend;
  logic [IW-1:0]    pend_idx;
  logic             found;
  logic [IW-1:0]    pos;
  logic             ev_flag;
  logic [KEY_W-1:0] ev_key;

  logic                   rsp_valid;
  logic                   rsp_hit;
  logic                   rsp_evicted;
  logic [KEY_W-1:0]       rsp_evicted_key;
  logic [COUNT_OUT_W-1:0] rsp_entry_count;

  logic [CW-1:0]    bound;
  logic [CW-1:0]    count_dec;
  logic             walk_issue;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             rd_hit;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  // Walker bound and read port address
  assign bound      = cmd.full_bound ? DEPTH_C : count;
  assign count_dec  = count - 1'b1;
  assign walk_issue = cmd.walk && (idx < bound);
  assign rd_en      = walk_issue || cmd.rd_last;
  assign rd_addr    = cmd.rd_last ? count_dec[IW-1:0] : idx[IW-1:0];
  assign rd_hit     = pend && (rdata == key);

  // Write port source select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key;
    case (cmd.wsel)
      W_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count[IW-1:0];
        wr_data = key;
      end
      W_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = rdata;
      end
      W_SHIFT: begin
        wr_en   = pend && (pend_idx != '0);
        wr_addr = IW'(pend_idx - 1'b1);
        wr_data = rdata;
      end
      W_LAST: begin
        wr_en   = 1'b1;
        wr_addr = LAST_SLOT;
        wr_data = key;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_slots[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= key_slots[rd_addr];
    end
  end

  // Request capture, match record and eviction record
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= key_code;
      take    <= req_type;
      found   <= 1'b0;
      pos     <= '0;
      ev_flag <= 1'b0;
      ev_key  <= '0;
    end else begin
      if (cmd.walk && !cmd.full_bound && rd_hit) begin
        found <= 1'b1;
        pos   <= pend_idx;
      end
      if ((cmd.wsel == W_SHIFT) && pend && (pend_idx == '0)) begin
        ev_key <= rdata;
      end
      if (cmd.mark_evict) begin
        ev_flag <= 1'b1;
      end
    end
  end

  // Slot walker and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      pend     <= 1'b0;
      pend_idx <= '0;
      count    <= '0;
    end else begin
      if (cmd.load || cmd.clr_walk) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.walk) begin
        idx      <= idx + CW'(walk_issue);
        pend     <= walk_issue;
        pend_idx <= idx[IW-1:0];
      end
      if (cmd.rd_last) begin
        count <= count_dec;
      end else if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end
    end
  end

  // Result register: hold until the sink takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_hit         <= found;
      rsp_evicted     <= ev_flag;
      rsp_evicted_key <= ev_key;
      rsp_entry_count <= COUNT_OUT_W'(count);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = rsp_hit;
  assign rsp.evicted     = rsp_evicted;
  assign rsp.evicted_key = rsp_evicted_key;
  assign rsp.entry_count = rsp_entry_count;

  // Status back to the controller
  assign sts.rd_hit   = rd_hit;
  assign sts.walk_end = !pend && !(idx < bound);
  assign sts.take     = take;
  assign sts.full     = (count == DEPTH_C);
  assign sts.out_free = !rsp_valid || rsp.ready;

endmodule

### rtl/core/kpt_ctrl.sv
// Controller of the key pair table: sequences search, move, append and shift.
// Depends on kpt_pkg; commands kpt_datapath through kpt_cmd_t.
module kpt_ctrl import kpt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  kpt_sts_t sts,
  output kpt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MV_RD,
    S_MV_WR,
    S_APPEND,
    S_SHIFT,
    S_LAST,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wsel   = W_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.walk = 1'b1;
        if (sts.rd_hit) begin
          state_next = sts.take ? S_MV_RD : S_DONE;
        end else if (sts.walk_end) begin
          if (sts.take) begin
            state_next = S_DONE;
          end else if (sts.full) begin
            cmd.clr_walk = 1'b1;
            state_next   = S_SHIFT;
          end else begin
            state_next = S_APPEND;
          end
        end
      end
      S_MV_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.wsel   = W_MOVE;
        state_next = S_DONE;
      end
      S_APPEND: begin
        cmd.wsel    = W_APPEND;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_SHIFT: begin
        cmd.walk       = 1'b1;
        cmd.full_bound = 1'b1;
        cmd.wsel       = W_SHIFT;
        if (sts.walk_end) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        cmd.wsel       = W_LAST;
        cmd.mark_evict = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

### rtl/core/key_pair_table_core.sv
// Top level of the key pair table: controller plus datapath with slot memory.
// Depends on kpt_pkg, kpt_if, kpt_ctrl and kpt_datapath.
//
//  channel  dir  payload                                    handshake
//  req      in   req_type, key_code                         req.valid / req.ready
//  rsp      out  hit, evicted, evicted_key, entry_count     rsp.valid / rsp.ready
//
// One request at a time; the search reads one slot per cycle from the slot memory.
// A search stops on a match or after reading every valid slot; an append adds a write,
// a take that hits adds a read of the last slot and a write into the matched slot for
// the move; an add on a full table shifts every slot down and writes the key last.
// Reset clears the count and control; the slot memory is not cleared.
// The result register holds its word while rsp.ready is low; a new request is taken
// meanwhile, and its result waits in the done state until the register frees up.
module key_pair_table_core import kpt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  kpt_req_if.sink req,
  kpt_rsp_if.source rsp
);

  kpt_cmd_t cmd;
  kpt_sts_t sts;

  kpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_type (req.req_type),
    .key_code (req.key_code),
    .rsp      (rsp)
  );

  // Block stays busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request port ready right after accept");

  // Never overwrite a result word the sink has not taken
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten before it was taken");

  // An eviction leaves the table full and is never a hit
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.evicted) |->
      (!rsp.hit && (rsp.entry_count == COUNT_OUT_W'(TABLE_DEPTH))))
    else $error("eviction reported on a table that is not full");

  // Count only moves while a request is in flight
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_inc || cmd.rd_last) |-> !req.ready)
    else $error("entry count changed while idle");

endmodule

### bench/tb_top.sv
// Self-checking bench for key_pair_table_core: drives add and take words, predicts each
// outcome from a local mirror of the key slots (or the directed table) and compares every response field.
// Depends on kpt_pkg and the request/response interfaces in kpt_if.
module tb_top import kpt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic                   hit;
    logic                   evicted;
    logic [KEY_W-1:0]       evicted_key;
    logic [COUNT_OUT_W-1:0] entry_count;
  } outcome_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             typed;
    outcome_t         want;
  } step_t;

  typedef enum {
    PH_STEADY,
    PH_SEND_SPARSE,
    PH_DRAIN_SLOW,
    PH_BOTH_SLOW,
    PH_BACKUP
  } traffic_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kpt_req_if req_if ();
  kpt_rsp_if rsp_if ();

  key_pair_table_core #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // Mirror of the key slots and the entry count
  logic [KEY_W-1:0] mirror_keys [DEPTH];
  int unsigned      mirror_used;

  outcome_t         outcome_q [$];
  logic [KEY_W-1:0] key_pool [24];
  traffic_t         traffic = PH_STEADY;

  int words_sent;
  int words_checked;
  int hit_count;
  int evict_count;
  int fail_count;
  int idle_cycles;

  // Directed words: empty take, duplicate add, miss, hit, fill to full, evictions
  step_t steps [24] = '{
    '{REQ_TAKE, 16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd0}},
    '{REQ_ADD,  16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd1}},
    '{REQ_ADD,  16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 5'd1}},
    '{REQ_ADD,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd2}},
    '{REQ_TAKE, 16'h1234, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd2}},
    '{REQ_TAKE, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 5'd1}},
    '{REQ_ADD,  16'h8000, 1'b0, '0},
    '{REQ_ADD,  16'h0001, 1'b0, '0},
    '{REQ_ADD,  16'h7FFF, 1'b0, '0},
    '{REQ_ADD,  16'h5555, 1'b0, '0},
    '{REQ_ADD,  16'hAAAA, 1'b0, '0},
    '{REQ_ADD,  16'h00FF, 1'b0, '0},
    '{REQ_ADD,  16'hFF00, 1'b0, '0},
    '{REQ_ADD,  16'h0F0F, 1'b0, '0},
    '{REQ_ADD,  16'hF0F0, 1'b0, '0},
    '{REQ_ADD,  16'h1111, 1'b0, '0},
    '{REQ_ADD,  16'h2222, 1'b0, '0},
    '{REQ_ADD,  16'h4444, 1'b0, '0},
    '{REQ_ADD,  16'h8888, 1'b0, '0},
    '{REQ_ADD,  16'h3333, 1'b0, '0},
    '{REQ_ADD,  16'hCCCC, 1'b0, '0},
    '{REQ_ADD,  16'hBEEF, 1'b1, '{1'b0, 1'b1, 16'h0000, 5'd16}},
    '{REQ_ADD,  16'hFFFF, 1'b0, '0},
    '{REQ_TAKE, 16'hBEEF, 1'b0, '0}
  };

  function automatic int idle_pct(traffic_t ph);
    case (ph)
      PH_SEND_SPARSE: return 82;
      PH_BOTH_SLOW:   return 13;
      default:        return 0;
    endcase
  endfunction

  function automatic int stall_pct(traffic_t ph);
    case (ph)
      PH_DRAIN_SLOW: return 82;
      PH_BOTH_SLOW:  return 13;
      default:       return 0;
    endcase
  endfunction

  // Apply one request to the mirror and return the outcome it should produce
  function automatic outcome_t pair_table_apply(logic kind, logic [KEY_W-1:0] key);
    outcome_t res;
    int       found;
    res   = '0;
    found = -1;
    for (int i = 0; i < int'(mirror_used); i++) begin
      if (found < 0 && mirror_keys[i] == key) found = i;
    end
    if (kind == REQ_TAKE) begin
      // move the last entry into the freed slot
      if (found >= 0) begin
        mirror_used--;
        mirror_keys[found] = mirror_keys[mirror_used];
        res.hit = 1'b1;
      end
    end else if (found >= 0) begin
      res.hit = 1'b1;
    end else if (mirror_used < DEPTH) begin
      mirror_keys[mirror_used] = key;
      mirror_used++;
    end else begin
      // drop slot zero, shift down, new key goes last
      res.evicted     = 1'b1;
      res.evicted_key = mirror_keys[0];
      for (int i = 1; i < DEPTH; i++) mirror_keys[i-1] = mirror_keys[i];
      mirror_keys[DEPTH-1] = key;
    end
    res.entry_count = COUNT_OUT_W'(mirror_used);
    return res;
  endfunction

  // Offer one word, hold it until accepted, then maybe go idle for a while
  task automatic offer_word(logic kind, logic [KEY_W-1:0] key, logic typed, outcome_t want);
    outcome_t predicted;
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.key_code <= key;
    do @(posedge clk); while (!req_if.ready);
    predicted = pair_table_apply(kind, key);
    outcome_q.push_back(typed ? want : predicted);
    words_sent++;
    if ($urandom_range(99) < idle_pct(traffic)) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct(traffic));
    end
  endtask

  // Random words: mostly pool keys or keys already in the table, so adds collide, takes hit and the table overflows
  task automatic run_traffic(traffic_t ph, int count);
    int               add_pct;
    int               pick;
    logic             kind;
    logic [KEY_W-1:0] key;
    traffic = ph;
    add_pct = 50;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 25;
          1:       add_pct = 55;
          default: add_pct = 80;
        endcase
      end
      kind = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_TAKE;
      pick = $urandom_range(99);
      if (kind == REQ_TAKE && pick < 65 && mirror_used > 0)
        key = mirror_keys[$urandom_range(mirror_used - 1)];
      else if (kind == REQ_ADD && pick < 15 && mirror_used > 0)
        key = mirror_keys[$urandom_range(mirror_used - 1)];
      else if (pick < 90)
        key = key_pool[$urandom_range(23)];
      else
        key = KEY_W'($urandom);
      offer_word(kind, key, 1'b0, '0);
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // Response side: random stalls, plus one long hold-off to back the block up
  initial begin : drain_side
    bit backed_up;
    backed_up = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (traffic == PH_BACKUP && !backed_up) begin
        backed_up = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct(traffic));
      end
    end
  end

  // Check each accepted response against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (outcome_q.size() == 0) begin
        $error("response word with no request outstanding");
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        words_checked++;
        if (rsp_if.hit === 1'b1) hit_count++;
        if (rsp_if.evicted === 1'b1) evict_count++;
        if (rsp_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
          fail_count++;
        end
        if (rsp_if.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp_if.evicted);
          fail_count++;
        end
        if (rsp_if.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, rsp_if.evicted_key);
          fail_count++;
        end
        if (rsp_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_if.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("no traffic for %0d cycles", STALL_LIMIT);
    $display("key_pair_table_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int waited;
    words_sent    = 0;
    words_checked = 0;
    hit_count     = 0;
    evict_count   = 0;
    fail_count    = 0;
    idle_cycles   = 0;
    mirror_used   = 0;
    foreach (mirror_keys[i]) mirror_keys[i] = '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_ADD;
    req_if.key_code <= '0;

    // hold reset, then release
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    traffic = PH_STEADY;
    foreach (steps[i]) offer_word(steps[i].kind, steps[i].key, steps[i].typed, steps[i].want);

    // random words across traffic patterns
    run_traffic(PH_STEADY,      230);
    run_traffic(PH_SEND_SPARSE, 230);
    run_traffic(PH_DRAIN_SLOW,  230);
    run_traffic(PH_BOTH_SLOW,   230);
    run_traffic(PH_BACKUP,       30);
    traffic = PH_STEADY;
    req_if.valid <= 1'b0;

    // drain outstanding responses, then give the block time to settle
    waited = 0;
    while (outcome_q.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);

    fail_count += outcome_q.size();
    $display("sent %0d request words, checked %0d responses (%0d hits, %0d evictions)",
             words_sent, words_checked, hit_count, evict_count);
    $display("traffic: back-to-back, sparse sender, slow receiver, both slow, long hold-off");
    if (fail_count == 0) begin
      $display("key_pair_table_core regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("key_pair_table_core regression: fail");
    end
    $finish;
  end

endmodule
